@@ hw/rtl/cht_pkg.sv @@
// Shared types and default sizes for the chained hash table.
package cht_pkg;

  localparam int NUM_BUCKETS_DEF = 16;
  localparam int POOL_DEPTH_DEF  = 64;
  localparam int KEY_WIDTH_DEF   = 31;

  localparam int STATUS_W = 3;
  localparam int BUCKET_W = 4;
  localparam int POS_W    = 7;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_PROBE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HEAD   = 3'd0,
    ST_APPEND = 3'd1,
    ST_FULL   = 3'd2,
    ST_FOUND  = 3'd3,
    ST_MISS   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_WALK,
    S_APPEND,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/chained_hash_table.sv @@
// Top level of the chained hash table: bucket unit, head and node memories, sequencer.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   op, key
//   out      output     out_valid / out_stall status, bucket, chain_pos, prev_key
//
// One item at a time. Each item passes the bucket unit (a direct mask for a power-of-two
// bucket count, else a reciprocal multiply and one correction), the head read, a walk over
// the chained nodes with one node memory read per cycle, an append step when a node is
// appended, and the result step. After reset every head word is cleared; no item is taken
// during the sweep. A finished result sits in the output register while the next item is
// accepted; a stalled output holds the sequencer.
module chained_hash_table #(
  parameter int NUM_BUCKETS = cht_pkg::NUM_BUCKETS_DEF,
  parameter int POOL_DEPTH  = cht_pkg::POOL_DEPTH_DEF,
  parameter int KEY_WIDTH   = cht_pkg::KEY_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [KEY_WIDTH-1:0]         key,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cht_pkg::STATUS_W-1:0] status,
  output logic [cht_pkg::BUCKET_W-1:0] bucket,
  output logic [cht_pkg::POS_W-1:0]    chain_pos,
  output logic [KEY_WIDTH-1:0]         prev_key
);

  localparam int BW  = $clog2(NUM_BUCKETS);
  localparam int LW  = $clog2(POOL_DEPTH + 1);
  localparam int NW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int HWD = 1 + KEY_WIDTH + LW;
  localparam int NWD = KEY_WIDTH + LW;

  logic           bkt_start;
  logic           bkt_done;
  logic [BW-1:0]  bkt;
  logic           hd_we;
  logic [BW-1:0]  hd_waddr;
  logic [HWD-1:0] hd_wdata;
  logic [HWD-1:0] hd_rdata;
  logic           nd_we;
  logic [NW-1:0]  nd_waddr;
  logic [NWD-1:0] nd_wdata;
  logic [NW-1:0]  nd_raddr;
  logic [NWD-1:0] nd_rdata;

  cht_bucket_mod #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_bucket (
    .clk   (clk),
    .rst   (rst),
    .start (bkt_start),
    .key   (key),
    .done  (bkt_done),
    .bkt   (bkt)
  );

  // head word: valid, key, link to first chained node
  cht_ram #(
    .DEPTH (NUM_BUCKETS),
    .WIDTH (HWD)
  ) u_head_mem (
    .clk   (clk),
    .we    (hd_we),
    .waddr (hd_waddr),
    .wdata (hd_wdata),
    .raddr (bkt),
    .rdata (hd_rdata)
  );

  // node word: key, link to next node
  cht_ram #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (NWD)
  ) u_node_mem (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (nd_wdata),
    .raddr (nd_raddr),
    .rdata (nd_rdata)
  );

  cht_ctrl #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .POOL_DEPTH  (POOL_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .bucket    (bucket),
    .chain_pos (chain_pos),
    .prev_key  (prev_key),
    .bkt_start (bkt_start),
    .bkt_done  (bkt_done),
    .bkt       (bkt),
    .hd_we     (hd_we),
    .hd_waddr  (hd_waddr),
    .hd_wdata  (hd_wdata),
    .hd_rdata  (hd_rdata),
    .nd_we     (nd_we),
    .nd_waddr  (nd_waddr),
    .nd_wdata  (nd_wdata),
    .nd_raddr  (nd_raddr),
    .nd_rdata  (nd_rdata)
  );

endmodule

@@ hw/rtl/cht_ram.sv @@
// Simple dual-port RAM, one write port and one registered read port.
module cht_ram #(
  parameter int DEPTH = cht_pkg::POOL_DEPTH_DEF,
  parameter int WIDTH = cht_pkg::KEY_WIDTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/cht_bucket_mod.sv @@
// Key modulo bucket count: direct mask for a power of two, else reciprocal multiply.
module cht_bucket_mod #(
  parameter int NUM_BUCKETS = cht_pkg::NUM_BUCKETS_DEF,
  parameter int KEY_WIDTH   = cht_pkg::KEY_WIDTH_DEF,
  localparam int BW = $clog2(NUM_BUCKETS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [KEY_WIDTH-1:0] key,
  output logic                 done,
  output logic [BW-1:0]        bkt
);

  localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
  localparam int PW = 2 * KEY_WIDTH;
  localparam int RW = KEY_WIDTH + BW;
  // floor(2^KEY_WIDTH / NUM_BUCKETS): the quotient estimate is exact or one low
  localparam logic [KEY_WIDTH-1:0] RECIP =
    KEY_WIDTH'((64'd1 << KEY_WIDTH) / NUM_BUCKETS);

  logic                 busy;
  logic                 phase;
  logic [KEY_WIDTH-1:0] sh;
  logic [PW-1:0]        prod;
  logic [RW-1:0]        qn;
  logic [RW-1:0]        rem;
  logic [RW-1:0]        rem_fix;

  // remainder lands in [0, 2*NUM_BUCKETS), one subtract corrects it
  always_comb begin
    rem = RW'(sh) - qn;
    if (rem >= RW'(NUM_BUCKETS)) begin
      rem_fix = rem - RW'(NUM_BUCKETS);
    end else begin
      rem_fix = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      if (IS_POW2) begin
        bkt  <= key[BW-1:0];
        done <= 1'b1;
        busy <= 1'b0;
      end else begin
        sh    <= key;
        prod  <= PW'(key) * PW'(RECIP);
        phase <= 1'b0;
        done  <= 1'b0;
        busy  <= 1'b1;
      end
    end else if (busy) begin
      if (!phase) begin
        qn    <= RW'(prod[PW-1:KEY_WIDTH]) * RW'(NUM_BUCKETS);
        phase <= 1'b1;
      end else begin
        bkt  <= rem_fix[BW-1:0];
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/cht_ctrl.sv @@
// Sequencer: head memory clear, head lookup, chain walk, node allocation and result register.
module cht_ctrl #(
  parameter int NUM_BUCKETS = cht_pkg::NUM_BUCKETS_DEF,
  parameter int POOL_DEPTH  = cht_pkg::POOL_DEPTH_DEF,
  parameter int KEY_WIDTH   = cht_pkg::KEY_WIDTH_DEF,
  localparam int BW  = $clog2(NUM_BUCKETS),
  localparam int LW  = $clog2(POOL_DEPTH + 1),
  localparam int NW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
  localparam int HWD = 1 + KEY_WIDTH + LW,
  localparam int NWD = KEY_WIDTH + LW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [KEY_WIDTH-1:0]          key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cht_pkg::STATUS_W-1:0]  status,
  output logic [cht_pkg::BUCKET_W-1:0]  bucket,
  output logic [cht_pkg::POS_W-1:0]     chain_pos,
  output logic [KEY_WIDTH-1:0]          prev_key,
  output logic                          bkt_start,
  input  logic                          bkt_done,
  input  logic [BW-1:0]                 bkt,
  output logic                          hd_we,
  output logic [BW-1:0]                 hd_waddr,
  output logic [HWD-1:0]                hd_wdata,
  input  logic [HWD-1:0]                hd_rdata,
  output logic                          nd_we,
  output logic [NW-1:0]                 nd_waddr,
  output logic [NWD-1:0]                nd_wdata,
  output logic [NW-1:0]                 nd_raddr,
  input  logic [NWD-1:0]                nd_rdata
);

  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);
  localparam logic [BW-1:0] LAST_BKT  = BW'(NUM_BUCKETS - 1);

  cht_pkg::state_t  state;
  cht_pkg::state_t  state_next;
  cht_pkg::op_t     cur_op;
  logic [KEY_WIDTH-1:0] cur_key;
  logic [BW-1:0]    clr_idx;
  logic [LW-1:0]    nodes_used;
  logic [LW-1:0]    link;
  logic [LW-1:0]    pos;
  cht_pkg::status_t res_status;
  logic [LW-1:0]    res_pos;
  logic [KEY_WIDTH-1:0] res_prev;

  logic                 hd_valid;
  logic [KEY_WIDTH-1:0] hd_key;
  logic [LW-1:0]        hd_next;
  logic [KEY_WIDTH-1:0] nd_key;
  logic [LW-1:0]        nd_next;
  logic                 pool_full;
  logic                 out_free;
  logic [31:0]          pos_ext;
  logic [31:0]          bkt_ext;

  assign hd_valid  = hd_rdata[HWD-1];
  assign hd_key    = hd_rdata[HWD-2:LW];
  assign hd_next   = hd_rdata[LW-1:0];
  assign nd_key    = nd_rdata[NWD-1:LW];
  assign nd_next   = nd_rdata[LW-1:0];
  assign pool_full = (nodes_used == NULL_LINK);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      cht_pkg::S_CLEAR: begin
        if (clr_idx == LAST_BKT) state_next = cht_pkg::S_IDLE;
      end
      cht_pkg::S_IDLE: begin
        if (in_valid) state_next = cht_pkg::S_HASH;
      end
      cht_pkg::S_HASH: begin
        if (bkt_done) state_next = cht_pkg::S_HEAD;
      end
      cht_pkg::S_HEAD: begin
        if (cur_op == cht_pkg::OP_INSERT) begin
          if (!hd_valid || pool_full) state_next = cht_pkg::S_DONE;
          else if (hd_next == NULL_LINK) state_next = cht_pkg::S_APPEND;
          else state_next = cht_pkg::S_WALK;
        end else begin
          if (!hd_valid || hd_key == cur_key || hd_next == NULL_LINK) begin
            state_next = cht_pkg::S_DONE;
          end else begin
            state_next = cht_pkg::S_WALK;
          end
        end
      end
      cht_pkg::S_WALK: begin
        if (cur_op == cht_pkg::OP_INSERT) begin
          if (nd_next == NULL_LINK) state_next = cht_pkg::S_APPEND;
        end else if (nd_key == cur_key || nd_next == NULL_LINK) begin
          state_next = cht_pkg::S_DONE;
        end
      end
      cht_pkg::S_APPEND: state_next = cht_pkg::S_DONE;
      cht_pkg::S_DONE: begin
        if (out_free) state_next = cht_pkg::S_IDLE;
      end
      default: state_next = cht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != cht_pkg::S_IDLE);
    bkt_start = (state == cht_pkg::S_IDLE) && in_valid;
    hd_we     = 1'b0;
    hd_waddr  = bkt;
    hd_wdata  = {1'b1, cur_key, NULL_LINK};
    nd_we     = 1'b0;
    nd_waddr  = nodes_used[NW-1:0];
    nd_wdata  = {cur_key, NULL_LINK};
    nd_raddr  = (state == cht_pkg::S_HEAD) ? hd_next[NW-1:0] : nd_next[NW-1:0];
    case (state)
      cht_pkg::S_CLEAR: begin
        hd_we    = 1'b1;
        hd_waddr = clr_idx;
        hd_wdata = {1'b0, {KEY_WIDTH{1'b0}}, NULL_LINK};
      end
      cht_pkg::S_HEAD: begin
        if (cur_op == cht_pkg::OP_INSERT) begin
          if (!hd_valid) begin
            hd_we = 1'b1;
          end else if (!pool_full && hd_next == NULL_LINK) begin
            // first chained node hangs off the head
            hd_we    = 1'b1;
            hd_wdata = {1'b1, hd_key, nodes_used};
          end
        end
      end
      cht_pkg::S_WALK: begin
        if (cur_op == cht_pkg::OP_INSERT && nd_next == NULL_LINK) begin
          nd_we    = 1'b1;
          nd_waddr = link[NW-1:0];
          nd_wdata = {nd_key, nodes_used};
        end
      end
      cht_pkg::S_APPEND: nd_we = 1'b1;
      default: ;
    endcase
  end

  assign pos_ext   = 32'(res_pos);
  assign bkt_ext   = 32'(bkt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cht_pkg::S_CLEAR;
      clr_idx    <= '0;
      nodes_used <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall && state != cht_pkg::S_DONE) out_valid <= 1'b0;
      case (state)
        cht_pkg::S_CLEAR: clr_idx <= clr_idx + BW'(1);
        cht_pkg::S_IDLE: begin
          if (in_valid) begin
            cur_op  <= cht_pkg::op_t'(op);
            cur_key <= key;
          end
        end
        cht_pkg::S_HEAD: begin
          link       <= hd_next;
          pos        <= LW'(1);
          res_pos    <= '0;
          res_prev   <= '0;
          res_status <= cht_pkg::ST_MISS;
          if (cur_op == cht_pkg::OP_INSERT) begin
            if (!hd_valid) begin
              res_status <= cht_pkg::ST_HEAD;
            end else if (pool_full) begin
              res_status <= cht_pkg::ST_FULL;
            end else begin
              res_status <= cht_pkg::ST_APPEND;
              res_pos    <= LW'(1);
              res_prev   <= hd_key;
            end
          end else if (hd_valid && hd_key == cur_key) begin
            res_status <= cht_pkg::ST_FOUND;
          end
        end
        cht_pkg::S_WALK: begin
          link <= nd_next;
          pos  <= pos + LW'(1);
          if (cur_op == cht_pkg::OP_INSERT) begin
            // keep the tail seen so far; the last node visited wins
            res_pos  <= pos + LW'(1);
            res_prev <= nd_key;
          end else if (nd_key == cur_key) begin
            res_status <= cht_pkg::ST_FOUND;
            res_pos    <= pos;
          end
        end
        cht_pkg::S_APPEND: nodes_used <= nodes_used + LW'(1);
        cht_pkg::S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= res_status;
            bucket    <= bkt_ext[cht_pkg::BUCKET_W-1:0];
            chain_pos <= pos_ext[cht_pkg::POS_W-1:0];
            prev_key  <= res_prev;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the chained hash table: directed cases, back-pressure, random traffic.
module tb;

  localparam int NB        = cht_pkg::NUM_BUCKETS_DEF;
  localparam int PD        = cht_pkg::POOL_DEPTH_DEF;
  localparam int KW        = cht_pkg::KEY_WIDTH_DEF;
  localparam int NULL_LINK = PD;
  localparam int LIMIT     = 1000000;
  localparam logic [KW-1:0] KEY_MAX = {KW{1'b1}};

  typedef struct packed {
    cht_pkg::status_t             status;
    logic [cht_pkg::BUCKET_W-1:0] bucket;
    logic [cht_pkg::POS_W-1:0]    chain_pos;
    logic [KW-1:0]                prev_key;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  cht_pkg::op_t op_in = cht_pkg::OP_INSERT;
  logic [KW-1:0] key_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [cht_pkg::STATUS_W-1:0] status;
  logic [cht_pkg::BUCKET_W-1:0] bucket;
  logic [cht_pkg::POS_W-1:0] chain_pos;
  logic [KW-1:0] prev_key;

  // shadow copy of the table
  bit            head_valid [NB];
  logic [KW-1:0] head_key [NB];
  int            head_next [NB];
  logic [KW-1:0] node_key [PD];
  int            node_next [PD];
  int            nodes_used;

  table_result_t pending_results[$];
  logic [KW-1:0] stored_keys[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 30;
  int recv_stall_pct = 30;
  int hold_left = 0;

  chained_hash_table i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op_in), .key(key_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .bucket(bucket), .chain_pos(chain_pos), .prev_key(prev_key)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("chained_hash_table regression: fail");
      $finish;
    end
  end

  // Walks the shadow table the same way the block does and updates it.
  function automatic table_result_t table_update(cht_pkg::op_t o, logic [KW-1:0] k);
    table_result_t r;
    int b;
    int link;
    int tail;
    int pos;
    logic [KW-1:0] tail_key;
    b = int'(k % NB);
    r.status    = cht_pkg::ST_MISS;
    r.bucket    = cht_pkg::BUCKET_W'(b);
    r.chain_pos = '0;
    r.prev_key  = '0;
    if (o == cht_pkg::OP_INSERT) begin
      if (!head_valid[b]) begin
        head_valid[b] = 1'b1;
        head_key[b]   = k;
        head_next[b]  = NULL_LINK;
        r.status      = cht_pkg::ST_HEAD;
      end else if (nodes_used >= PD) begin
        r.status = cht_pkg::ST_FULL;
      end else begin
        tail_key = head_key[b];
        tail     = NULL_LINK;
        link     = head_next[b];
        pos      = 0;
        while (link != NULL_LINK && pos < PD) begin
          tail     = link;
          tail_key = node_key[link];
          link     = node_next[link];
          pos++;
        end
        node_key[nodes_used]  = k;
        node_next[nodes_used] = NULL_LINK;
        if (tail != NULL_LINK) node_next[tail] = nodes_used;
        else head_next[b] = nodes_used;
        nodes_used++;
        r.status    = cht_pkg::ST_APPEND;
        r.chain_pos = cht_pkg::POS_W'(pos + 1);
        r.prev_key  = tail_key;
      end
    end else if (head_valid[b]) begin
      if (head_key[b] == k) begin
        r.status = cht_pkg::ST_FOUND;
      end else begin
        link = head_next[b];
        pos  = 1;
        while (link != NULL_LINK && pos <= PD && r.status != cht_pkg::ST_FOUND) begin
          if (node_key[link] == k) begin
            r.status    = cht_pkg::ST_FOUND;
            r.chain_pos = cht_pkg::POS_W'(pos);
          end else begin
            link = node_next[link];
            pos++;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic send_item(cht_pkg::op_t o, logic [KW-1:0] k);
    table_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op_in    <= o;
    key_in   <= k;
    do @(posedge clk); while (in_stall);
    r = table_update(o, k);
    pending_results.push_back(r);
    if (r.status == cht_pkg::ST_HEAD || r.status == cht_pkg::ST_APPEND) begin
      stored_keys.push_back(k);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // receiver: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    table_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d bucket %0d", status, bucket);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (bucket !== want.bucket) begin
          $error("bucket: expected %0d, got %0d", want.bucket, bucket);
          errors++;
        end
        if (chain_pos !== want.chain_pos) begin
          $error("chain_pos: expected %0d, got %0d", want.chain_pos, chain_pos);
          errors++;
        end
        if (prev_key !== want.prev_key) begin
          $error("prev_key: expected %0h, got %0h", want.prev_key, prev_key);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_probes();
    send_item(cht_pkg::OP_PROBE, '0);
    send_item(cht_pkg::OP_PROBE, KEY_MAX);
  endtask

  task automatic test_head_and_chain();
    send_item(cht_pkg::OP_INSERT, '0);
    send_item(cht_pkg::OP_INSERT, KEY_MAX);
    send_item(cht_pkg::OP_INSERT, KW'(16));
    send_item(cht_pkg::OP_INSERT, KW'(32));
    send_item(cht_pkg::OP_INSERT, '0);            // duplicate goes to the tail
    send_item(cht_pkg::OP_PROBE, '0);             // first match is the head
    send_item(cht_pkg::OP_PROBE, KW'(32));
    send_item(cht_pkg::OP_PROBE, KW'(48));        // bucket in use, key absent
    send_item(cht_pkg::OP_PROBE, KEY_MAX);
    send_item(cht_pkg::OP_PROBE, {KEY_MAX[KW-1:4], 4'd0});
    send_item(cht_pkg::OP_INSERT, KW'(31'h5555_5555));
    send_item(cht_pkg::OP_INSERT, KW'(31'h2AAA_AAAA));
    send_item(cht_pkg::OP_PROBE, KW'(31'h5555_5555));
    send_item(cht_pkg::OP_PROBE, KW'(31'h2AAA_AAAA));
  endtask

  // deep chain in one bucket so probes and appends walk many nodes
  task automatic test_long_chain();
    logic [KW-1:0] k;
    while (nodes_used < 40) begin
      k = {(KW-4)'($urandom), 4'd9};
      send_item(cht_pkg::OP_INSERT, k);
      if ($urandom_range(3) == 0)
        send_item(cht_pkg::OP_PROBE, stored_keys[$urandom_range(stored_keys.size() - 1)]);
    end
    send_item(cht_pkg::OP_PROBE, {(KW-4)'($urandom), 4'd9});
  endtask

  task automatic test_output_hold();
    hold_left = 300;
    repeat (12) begin
      send_item(cht_pkg::OP_PROBE, stored_keys[$urandom_range(stored_keys.size() - 1)]);
    end
  endtask

  task automatic test_drain_pause();
    send_item(cht_pkg::OP_PROBE, stored_keys[stored_keys.size() - 1]);
    wait_drained();
    send_item(cht_pkg::OP_INSERT, {(KW-4)'($urandom), 4'd9});
  endtask

  task automatic test_random_traffic();
    logic [KW-1:0] k;
    for (int i = 0; i < 1080; i++) begin
      if (i == 400) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if (i == 560) begin
        send_idle_pct  = 30;
        recv_stall_pct = 30;
      end
      if ($urandom_range(99) < 45) begin
        k = KW'($urandom);
        if ($urandom_range(99) < 40) k[3:0] = 4'd9;
        send_item(cht_pkg::OP_INSERT, k);
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: k = stored_keys[$urandom_range(stored_keys.size() - 1)];
          6: begin
            k = stored_keys[$urandom_range(stored_keys.size() - 1)];
            k = k ^ (KW'(1) << (4 + $urandom_range(KW - 5)));
          end
          default: k = KW'($urandom);
        endcase
        send_item(cht_pkg::OP_PROBE, k);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NB; i++) begin
      head_valid[i] = 1'b0;
      head_key[i]   = '0;
      head_next[i]  = NULL_LINK;
    end
    for (int i = 0; i < PD; i++) begin
      node_key[i]  = '0;
      node_next[i] = NULL_LINK;
    end
    nodes_used = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_probes();
    test_head_and_chain();
    test_long_chain();
    test_output_hold();
    test_drain_pause();
    test_random_traffic();
    wait_drained();
    repeat (2 * PD + 20) @(posedge clk);
    if (errors == 0) begin
      $display("chained_hash_table regression: pass");
    end else begin
      $display("chained_hash_table regression: fail");
    end
    $finish;
  end

endmodule
